@@ hdl/sesd_pkg.sv @@
`timescale 1ns / 1ps
package sesd_pkg;

    localparam int MAX_LEN      = 256;
    localparam int SYMBOL_BITS  = 32;
    localparam int LEN_W        = $clog2(MAX_LEN + 1);
    localparam int ADDR_W       = $clog2(MAX_LEN);
    localparam int SCRIPT_DEPTH = 2 * MAX_LEN;
    localparam int SCRIPT_AW    = $clog2(SCRIPT_DEPTH);
    localparam int DIST_W       = $clog2(SCRIPT_DEPTH + 1);
    localparam int TRACE_DEPTH  = ((2 * MAX_LEN + 1) * (2 * MAX_LEN + 2)) / 2;
    localparam int TRACE_AW     = $clog2(TRACE_DEPTH);
    localparam int POS_W        = DIST_W + 1;
    localparam int DIAG_W       = POS_W + 2;

    typedef enum logic [2:0] {
        CMD_CLEAR    = 3'd0,
        CMD_APPEND_A = 3'd1,
        CMD_APPEND_B = 3'd2,
        CMD_COMPUTE  = 3'd3,
        CMD_FETCH    = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_STEP   = 2'd1,
        KIND_END    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        OP_EQUAL  = 2'd0,
        OP_DELETE = 2'd1,
        OP_INSERT = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_X,
        S_SNK,
        S_CMP,
        S_WR,
        S_B0,
        S_B1,
        S_B2,
        S_B3,
        S_TAIL,
        S_DONE
    } state_t;

endpackage

@@ hdl/sesd_cmd_if.sv @@
`timescale 1ns / 1ps
interface sesd_cmd_if
    import sesd_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [2:0]             command;
    logic [31:0]            symbol;

    modport source (output valid, command, symbol, input ready);
    modport sink (input valid, command, symbol, output ready);
endinterface

@@ hdl/sesd_res_if.sv @@
`timescale 1ns / 1ps
interface sesd_res_if
    import sesd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [1:0]        op;
    logic [8:0]        line_a;
    logic [8:0]        line_b;
    logic [9:0]        distance;
    logic              overflow;
    logic              last;

    modport source (output valid, kind, op, line_a, line_b, distance, overflow, last,
                    input ready);
    modport sink (input valid, kind, op, line_a, line_b, distance, overflow, last,
                  output ready);
endinterface

@@ hdl/sesd_ram.sv @@
`timescale 1ns / 1ps
module sesd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/shortest_edit_script_diff.sv @@
`timescale 1ns / 1ps
// channel | dir | word fields
// cmd     | in  | command[2:0], symbol[31:0]
// res     | out | kind, op, line_a, line_b, distance, overflow, last
//
// Clear, append and fetch are handled in the idle state; a word is accepted every cycle
// while the result register is free or being drained.
// Compute runs the diagonal search over the trace memory: one read and one write
// per diagonal plus S_SNK and S_CMP per matched token, then S_B0 to S_B3 per backtrack
// round with equal steps in S_B3 or S_TAIL, an order set by the single read port of each memory.
// Reset clears lengths, script pointers and flags; memories hold no reset state.
// Input stalls while compute runs or while a result waits without ready.
module shortest_edit_script_diff
    import sesd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    sesd_cmd_if.sink   cmd,
    sesd_res_if.source res
);

    state_t state_reg, state_next;

    logic [LEN_W-1:0]    len_a_reg, len_a_next, len_b_reg, len_b_next;
    logic                ovf_reg, ovf_next;
    logic [DIST_W-1:0]   slen_reg, slen_next, rptr_reg, rptr_next, dist_reg, dist_next;
    logic [LEN_W-1:0]    fa_reg, fa_next, fb_reg, fb_next;

    logic                rv_reg, rv_next;
    logic [1:0]          rkind_reg, rkind_next, rop_reg, rop_next;
    logic [8:0]          rla_reg, rla_next, rlb_reg, rlb_next;
    logic [DIST_W-1:0]   rdist_reg, rdist_next;
    logic                rovf_reg, rovf_next, rlast_reg, rlast_next;

    logic [DIST_W-1:0]   d_reg, d_next, j_reg, j_next, fin_reg, fin_next;
    logic signed [DIAG_W-1:0] k_reg, k_next, y_reg, y_next;
    logic [TRACE_AW-1:0] base_reg, base_next, bprev_reg, bprev_next;
    logic [POS_W-1:0]    left_reg, left_next, right_reg, right_next, x_reg, x_next;

    logic [DIST_W-1:0]   tot_reg, tot_next, pos_reg, pos_next, dd_reg, dd_next;
    logic [LEN_W-1:0]    cx_reg, cx_next, cy_reg, cy_next;
    logic [TRACE_AW-1:0] btb_reg, btb_next;
    logic [POS_W-1:0]    vl_reg, vl_next, px_reg, px_next;
    logic signed [DIAG_W-1:0] py_reg, py_next;
    logic                down_reg, down_next;

    logic                a_we, b_we, t_we, s_we;
    logic [SYMBOL_BITS-1:0] a_rd, b_rd;
    logic [TRACE_AW-1:0] t_waddr, t_raddr;
    logic [POS_W-1:0]    t_rd;
    logic [SCRIPT_AW-1:0] s_waddr;
    logic [1:0]          s_wdata, s_rd;

    logic                out_free, acc;
    logic signed [DIAG_W-1:0] d_s, dd_s, kk, jl, jr, jmax, x_s;
    logic                jl_ok, jr_ok;
    logic [POS_W-1:0]    right_cur, n_ext, m_ext;
    logic [DIST_W:0]     tot_sum;

    assign out_free  = !rv_reg || res.ready;
    assign cmd.ready = (state_reg == S_IDLE) && out_free;
    assign acc       = cmd.valid && cmd.ready;

    assign d_s   = signed'({{(DIAG_W-DIST_W){1'b0}}, d_reg});
    assign dd_s  = signed'({{(DIAG_W-DIST_W){1'b0}}, dd_reg});
    assign x_s   = signed'({{(DIAG_W-POS_W){1'b0}}, x_reg});
    assign n_ext = {{(POS_W-LEN_W){1'b0}}, len_a_reg};
    assign m_ext = {{(POS_W-LEN_W){1'b0}}, len_b_reg};
    assign kk    = signed'({{(DIAG_W-LEN_W){1'b0}}, cx_reg})
                 - signed'({{(DIAG_W-LEN_W){1'b0}}, cy_reg});
    assign jl    = kk + dd_s - DIAG_W'(2);
    assign jr    = kk + dd_s;
    assign jmax  = (dd_s - DIAG_W'(1)) <<< 1;
    assign jl_ok = (jl >= 0) && (jl <= jmax) && !jl[0];
    assign jr_ok = (jr >= 0) && (jr <= jmax) && !jr[0];
    assign tot_sum = {2'b0, len_a_reg} + {2'b0, len_b_reg} + {1'b0, d_reg};
    assign right_cur = (d_reg == '0) ? '0 : t_rd;

    sesd_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(MAX_LEN)) u_seq_a (
        .clk(clk), .we(a_we), .waddr(len_a_reg[ADDR_W-1:0]),
        .wdata(cmd.symbol[SYMBOL_BITS-1:0]),
        .raddr(x_reg[ADDR_W-1:0]), .rdata(a_rd)
    );

    sesd_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(MAX_LEN)) u_seq_b (
        .clk(clk), .we(b_we), .waddr(len_b_reg[ADDR_W-1:0]),
        .wdata(cmd.symbol[SYMBOL_BITS-1:0]),
        .raddr(y_reg[ADDR_W-1:0]), .rdata(b_rd)
    );

    sesd_ram #(.WIDTH(POS_W), .DEPTH(TRACE_DEPTH)) u_trace (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(x_reg),
        .raddr(t_raddr), .rdata(t_rd)
    );

    sesd_ram #(.WIDTH(2), .DEPTH(SCRIPT_DEPTH)) u_script (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(rptr_next[SCRIPT_AW-1:0]), .rdata(s_rd)
    );

    assign t_waddr = base_reg + TRACE_AW'(j_reg);

    always_comb
    begin
        case (state_reg)
            S_B0:    t_raddr = btb_reg + TRACE_AW'(jl[DIAG_W-1:1]);
            S_B1:    t_raddr = btb_reg + TRACE_AW'(jr[DIAG_W-1:1]);
            default: t_raddr = bprev_reg + TRACE_AW'(j_reg);
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc && cmd.command == CMD_COMPUTE)
                begin
                    state_next = S_X;
                end
            end
            S_RD:   state_next = S_X;
            S_X:    state_next = S_SNK;
            S_SNK:
            begin
                if (x_reg < n_ext && y_reg >= 0 && y_reg < signed'({2'b0, m_ext}))
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    state_next = S_WR;
                end
            end
            S_CMP:  state_next = (a_rd == b_rd) ? S_SNK : S_WR;
            S_WR:
            begin
                if (x_reg >= n_ext && y_reg >= signed'({2'b0, m_ext}))
                begin
                    state_next = S_B0;
                end
                else if (k_reg == d_s || k_reg + DIAG_W'(2) != d_s)
                begin
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_X;
                end
            end
            S_B0:   state_next = (dd_reg == '0) ? S_TAIL : S_B1;
            S_B1:   state_next = S_B2;
            S_B2:   state_next = S_B3;
            S_B3:
            begin
                if (!({1'b0, {(POS_W-LEN_W){1'b0}}, cx_reg} > {1'b0, px_reg}
                      && signed'({{(DIAG_W-LEN_W){1'b0}}, cy_reg}) > py_reg))
                begin
                    state_next = S_B0;
                end
            end
            S_TAIL:
            begin
                if (!(cx_reg != '0 && cy_reg != '0))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        len_a_next = len_a_reg;
        len_b_next = len_b_reg;
        ovf_next   = ovf_reg;
        slen_next  = slen_reg;
        rptr_next  = rptr_reg;
        dist_next  = dist_reg;
        fa_next    = fa_reg;
        fb_next    = fb_reg;
        rv_next    = rv_reg && !res.ready;
        rkind_next = rkind_reg;
        rop_next   = rop_reg;
        rla_next   = rla_reg;
        rlb_next   = rlb_reg;
        rdist_next = rdist_reg;
        rovf_next  = rovf_reg;
        rlast_next = rlast_reg;
        d_next     = d_reg;
        j_next     = j_reg;
        fin_next   = fin_reg;
        k_next     = k_reg;
        y_next     = y_reg;
        base_next  = base_reg;
        bprev_next = bprev_reg;
        left_next  = left_reg;
        right_next = right_reg;
        x_next     = x_reg;
        tot_next   = tot_reg;
        pos_next   = pos_reg;
        dd_next    = dd_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        btb_next   = btb_reg;
        vl_next    = vl_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        down_next  = down_reg;
        a_we       = 1'b0;
        b_we       = 1'b0;
        t_we       = 1'b0;
        s_we       = 1'b0;
        s_waddr    = pos_reg[SCRIPT_AW-1:0] - SCRIPT_AW'(1);
        s_wdata    = OP_EQUAL;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    case (cmd.command)
                        CMD_CLEAR:
                        begin
                            len_a_next = '0;
                            len_b_next = '0;
                            slen_next  = '0;
                            rptr_next  = '0;
                            dist_next  = '0;
                            ovf_next   = 1'b0;
                            fa_next    = '0;
                            fb_next    = '0;
                        end
                        CMD_APPEND_A:
                        begin
                            if (len_a_reg < LEN_W'(MAX_LEN))
                            begin
                                a_we       = 1'b1;
                                len_a_next = len_a_reg + LEN_W'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        CMD_APPEND_B:
                        begin
                            if (len_b_reg < LEN_W'(MAX_LEN))
                            begin
                                b_we       = 1'b1;
                                len_b_next = len_b_reg + LEN_W'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        CMD_COMPUTE:
                        begin
                            d_next     = '0;
                            k_next     = '0;
                            j_next     = '0;
                            base_next  = '0;
                            bprev_next = '0;
                            left_next  = '0;
                        end
                        CMD_FETCH:
                        begin
                            rv_next    = 1'b1;
                            rdist_next = dist_reg;
                            rovf_next  = ovf_reg;
                            rop_next   = OP_EQUAL;
                            rla_next   = '0;
                            rlb_next   = '0;
                            rlast_next = 1'b0;
                            if (rptr_reg < slen_reg)
                            begin
                                rkind_next = KIND_STEP;
                                rop_next   = s_rd;
                                rptr_next  = rptr_reg + DIST_W'(1);
                                rlast_next = (rptr_reg + DIST_W'(1)) == slen_reg;
                                if (s_rd != OP_INSERT)
                                begin
                                    fa_next  = fa_reg + LEN_W'(1);
                                    rla_next = fa_reg + LEN_W'(1);
                                end
                                if (s_rd != OP_DELETE)
                                begin
                                    fb_next  = fb_reg + LEN_W'(1);
                                    rlb_next = fb_reg + LEN_W'(1);
                                end
                            end
                            else
                            begin
                                rkind_next = KIND_END;
                            end
                        end
                        default:
                        begin
                            rv_next = rv_reg && !res.ready;
                        end
                    endcase
                end
            end
            S_X:
            begin
                right_next = right_cur;
                if (k_reg == -d_s)
                begin
                    x_next = right_cur;
                end
                else if (k_reg != d_s && left_reg < right_cur)
                begin
                    x_next = right_cur;
                end
                else
                begin
                    x_next = left_reg + POS_W'(1);
                end
                y_next = signed'({{(DIAG_W-POS_W){1'b0}}, x_next}) - k_reg;
            end
            S_CMP:
            begin
                if (a_rd == b_rd)
                begin
                    x_next = x_reg + POS_W'(1);
                    y_next = y_reg + DIAG_W'(1);
                end
            end
            S_WR:
            begin
                t_we      = 1'b1;
                left_next = right_reg;
                if (x_reg >= n_ext && y_reg >= signed'({2'b0, m_ext}))
                begin
                    fin_next = d_reg;
                    tot_next = tot_sum[DIST_W:1];
                    pos_next = tot_sum[DIST_W:1];
                    cx_next  = len_a_reg;
                    cy_next  = len_b_reg;
                    dd_next  = d_reg;
                    btb_next = bprev_reg;
                end
                else if (k_reg == d_s)
                begin
                    d_next     = d_reg + DIST_W'(1);
                    k_next     = -(d_s + DIAG_W'(1));
                    j_next     = '0;
                    bprev_next = base_reg;
                    base_next  = base_reg + TRACE_AW'(d_reg) + TRACE_AW'(1);
                end
                else
                begin
                    k_next = k_reg + DIAG_W'(2);
                    j_next = j_reg + DIST_W'(1);
                end
            end
            S_B1:
            begin
                vl_next = jl_ok ? t_rd : '0;
            end
            S_B2:
            begin
                down_next = (kk == -dd_s)
                         || (kk != dd_s && vl_reg < (jr_ok ? t_rd : POS_W'(0)));
                if (down_next)
                begin
                    px_next = jr_ok ? t_rd : '0;
                    py_next = signed'({{(DIAG_W-POS_W){1'b0}}, px_next}) - (kk + DIAG_W'(1));
                end
                else
                begin
                    px_next = vl_reg;
                    py_next = signed'({{(DIAG_W-POS_W){1'b0}}, px_next}) - (kk - DIAG_W'(1));
                end
            end
            S_B3:
            begin
                if (pos_reg != '0)
                begin
                    s_we     = 1'b1;
                    pos_next = pos_reg - DIST_W'(1);
                end
                if ({1'b0, {(POS_W-LEN_W){1'b0}}, cx_reg} > {1'b0, px_reg}
                    && signed'({{(DIAG_W-LEN_W){1'b0}}, cy_reg}) > py_reg)
                begin
                    s_wdata = OP_EQUAL;
                    cx_next = cx_reg - LEN_W'(1);
                    cy_next = cy_reg - LEN_W'(1);
                end
                else
                begin
                    dd_next  = dd_reg - DIST_W'(1);
                    btb_next = btb_reg - TRACE_AW'(dd_reg - DIST_W'(1));
                    if (down_reg)
                    begin
                        s_wdata = OP_INSERT;
                        cy_next = cy_reg - LEN_W'(1);
                    end
                    else
                    begin
                        s_wdata = OP_DELETE;
                        cx_next = cx_reg - LEN_W'(1);
                    end
                end
            end
            S_TAIL:
            begin
                if (cx_reg != '0 && cy_reg != '0)
                begin
                    if (pos_reg != '0)
                    begin
                        s_we     = 1'b1;
                        pos_next = pos_reg - DIST_W'(1);
                    end
                    cx_next = cx_reg - LEN_W'(1);
                    cy_next = cy_reg - LEN_W'(1);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    slen_next  = tot_reg - pos_reg;
                    rptr_next  = '0;
                    dist_next  = fin_reg;
                    fa_next    = '0;
                    fb_next    = '0;
                    rv_next    = 1'b1;
                    rkind_next = KIND_STATUS;
                    rop_next   = OP_EQUAL;
                    rla_next   = '0;
                    rlb_next   = '0;
                    rdist_next = fin_reg;
                    rovf_next  = ovf_reg;
                    rlast_next = 1'b0;
                end
            end
            default:
            begin
                x_next = x_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_a_reg <= '0;
            len_b_reg <= '0;
            ovf_reg   <= 1'b0;
            slen_reg  <= '0;
            rptr_reg  <= '0;
            dist_reg  <= '0;
            fa_reg    <= '0;
            fb_reg    <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_a_reg <= len_a_next;
            len_b_reg <= len_b_next;
            ovf_reg   <= ovf_next;
            slen_reg  <= slen_next;
            rptr_reg  <= rptr_next;
            dist_reg  <= dist_next;
            fa_reg    <= fa_next;
            fb_reg    <= fb_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rkind_reg <= rkind_next;
        rop_reg   <= rop_next;
        rla_reg   <= rla_next;
        rlb_reg   <= rlb_next;
        rdist_reg <= rdist_next;
        rovf_reg  <= rovf_next;
        rlast_reg <= rlast_next;
        d_reg     <= d_next;
        j_reg     <= j_next;
        fin_reg   <= fin_next;
        k_reg     <= k_next;
        y_reg     <= y_next;
        base_reg  <= base_next;
        bprev_reg <= bprev_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        x_reg     <= x_next;
        tot_reg   <= tot_next;
        pos_reg   <= pos_next;
        dd_reg    <= dd_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        btb_reg   <= btb_next;
        vl_reg    <= vl_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        down_reg  <= down_next;
    end

    assign res.valid    = rv_reg;
    assign res.kind     = rkind_reg;
    assign res.op       = rop_reg;
    assign res.line_a   = rla_reg;
    assign res.line_b   = rlb_reg;
    assign res.distance = rdist_reg;
    assign res.overflow = rovf_reg;
    assign res.last     = rlast_reg;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
    import sesd_pkg::*;

    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
    localparam int         DIAG_SPAN       = 4 * MAX_LEN + 2;
    localparam longint     CYCLE_LIMIT     = 4000000;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] op;
        logic [8:0] line_a;
        logic [8:0] line_b;
        logic [9:0] distance;
        logic       overflow;
        logic       last;
    } res_word_t;

    class diff_scoreboard;
        logic [31:0] seq_a [MAX_LEN];
        logic [31:0] seq_b [MAX_LEN];
        int          len_a, len_b;
        int          frontier [DIAG_SPAN];
        int          trace [];
        int          script [SCRIPT_DEPTH];
        int          script_len, read_ptr, distance, line_a, line_b;
        bit          overflow;
        res_word_t   pending [$];
        int          errors;

        function new();
            trace = new[TRACE_DEPTH];
        endfunction

        function int tri_base(int d);
            return (d * (d + 1)) / 2;
        endfunction

        function int trace_at(int d, int k);
            int j;
            int pos;
            j = k + d;
            if (d < 0 || j < 0 || j > 2 * d || (j & 1))
                return 0;
            pos = tri_base(d) + j / 2;
            if (pos < 0 || pos >= TRACE_DEPTH)
                return 0;
            return trace[pos];
        endfunction

        function void put_op(inout int pos, input int op);
            if (pos > 0 && pos <= SCRIPT_DEPTH)
            begin
                pos--;
                script[pos] = op;
            end
        endfunction

        function void search();
            int n, m, mx, d, k, fin, x, y, idx, tp, cx, cy, dd, kk, px, py, total, pos;
            bit found, down;
            n = len_a;
            m = len_b;
            mx = n + m;
            fin = 0;
            found = 0;
            foreach (frontier[i])
                frontier[i] = 0;
            for (d = 0; d <= mx && !found; d++)
            begin
                for (k = -d; k <= d; k += 2)
                begin
                    idx = k + mx;
                    if (idx < 0 || idx + 1 >= DIAG_SPAN)
                        continue;
                    if (k == -d || (k != d && frontier[idx - 1] < frontier[idx + 1]))
                        x = frontier[idx + 1];
                    else
                        x = frontier[idx - 1] + 1;
                    y = x - k;
                    while (x < n && y >= 0 && y < m && seq_a[x] == seq_b[y])
                    begin
                        x++;
                        y++;
                    end
                    frontier[idx] = x;
                    tp = tri_base(d) + (k + d) / 2;
                    if (tp >= 0 && tp < TRACE_DEPTH)
                        trace[tp] = x;
                    if (x >= n && y >= m)
                    begin
                        found = 1;
                        fin = d;
                        break;
                    end
                end
            end
            total = (n + m + fin) / 2;
            if (total > SCRIPT_DEPTH)
                total = SCRIPT_DEPTH;
            pos = total;
            cx = n;
            cy = m;
            for (dd = fin; dd > 0; dd--)
            begin
                kk = cx - cy;
                down = (kk == -dd) ||
                       (kk != dd && trace_at(dd - 1, kk - 1) < trace_at(dd - 1, kk + 1));
                if (down)
                begin
                    px = trace_at(dd - 1, kk + 1);
                    py = px - (kk + 1);
                end
                else
                begin
                    px = trace_at(dd - 1, kk - 1);
                    py = px - (kk - 1);
                end
                while (cx > px && cy > py)
                begin
                    put_op(pos, OP_EQUAL);
                    cx--;
                    cy--;
                end
                if (down)
                begin
                    put_op(pos, OP_INSERT);
                    cy--;
                end
                else
                begin
                    put_op(pos, OP_DELETE);
                    cx--;
                end
            end
            while (cx > 0 && cy > 0)
            begin
                put_op(pos, OP_EQUAL);
                cx--;
                cy--;
            end
            for (int i = 0; i < total - pos; i++)
                script[i] = script[i + pos];
            script_len = total - pos;
            distance = fin;
            read_ptr = 0;
            line_a = 0;
            line_b = 0;
        endfunction

        function void note(logic [2:0] command, logic [31:0] symbol);
            res_word_t w;
            w = '0;
            case (command)
                CMD_CLEAR:
                begin
                    len_a = 0;
                    len_b = 0;
                    script_len = 0;
                    read_ptr = 0;
                    distance = 0;
                    overflow = 0;
                    line_a = 0;
                    line_b = 0;
                    return;
                end
                CMD_APPEND_A:
                begin
                    if (len_a < MAX_LEN)
                        seq_a[len_a++] = symbol;
                    else
                        overflow = 1;
                    return;
                end
                CMD_APPEND_B:
                begin
                    if (len_b < MAX_LEN)
                        seq_b[len_b++] = symbol;
                    else
                        overflow = 1;
                    return;
                end
                CMD_COMPUTE:
                begin
                    search();
                    w.kind = KIND_STATUS;
                end
                CMD_FETCH:
                begin
                    if (read_ptr < script_len && read_ptr < SCRIPT_DEPTH)
                    begin
                        w.op = 2'(script[read_ptr]);
                        if (w.op != OP_INSERT)
                        begin
                            line_a++;
                            w.line_a = 9'(line_a);
                        end
                        if (w.op != OP_DELETE)
                        begin
                            line_b++;
                            w.line_b = 9'(line_b);
                        end
                        read_ptr++;
                        w.last = (read_ptr == script_len);
                        w.kind = KIND_STEP;
                    end
                    else
                        w.kind = KIND_END;
                end
                default:
                    return;
            endcase
            w.distance = 10'(distance);
            w.overflow = overflow;
            pending = {pending, w};
        endfunction

        function void check(res_word_t got);
            res_word_t exp_w;
            if (pending.size() == 0)
            begin
                $error("unexpected result word kind=%0d", got.kind);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got.kind !== exp_w.kind)
            begin
                $error("kind: expected %0d, got %0d", exp_w.kind, got.kind);
                errors++;
            end
            if (got.op !== exp_w.op)
            begin
                $error("op: expected %0d, got %0d", exp_w.op, got.op);
                errors++;
            end
            if (got.line_a !== exp_w.line_a)
            begin
                $error("line_a: expected %0d, got %0d", exp_w.line_a, got.line_a);
                errors++;
            end
            if (got.line_b !== exp_w.line_b)
            begin
                $error("line_b: expected %0d, got %0d", exp_w.line_b, got.line_b);
                errors++;
            end
            if (got.distance !== exp_w.distance)
            begin
                $error("distance: expected %0d, got %0d", exp_w.distance, got.distance);
                errors++;
            end
            if (got.overflow !== exp_w.overflow)
            begin
                $error("overflow: expected %0d, got %0d", exp_w.overflow, got.overflow);
                errors++;
            end
            if (got.last !== exp_w.last)
            begin
                $error("last: expected %0d, got %0d", exp_w.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic   clk;
    logic   rst_n;
    int     src_idle_pct;
    int     snk_idle_pct;
    int     hold_left;
    longint cycles;

    diff_scoreboard sb;

    sesd_cmd_if cmd ();
    sesd_res_if res ();

    shortest_edit_script_diff dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd.sink),
        .res   (res.source)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
            sb.check({res.kind, res.op, res.line_a, res.line_b, res.distance,
                      res.overflow, res.last});
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            res.ready <= 1'b0;
        end
        else
            res.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic send(logic [2:0] command, logic [31:0] symbol);
        while ($urandom_range(99) < src_idle_pct)
        begin
            cmd.valid <= 1'b0;
            @(negedge clk);
        end
        cmd.valid   <= 1'b1;
        cmd.command <= command;
        cmd.symbol  <= symbol;
        do
            @(posedge clk);
        while (!cmd.ready);
        sb.note(command, symbol);
        @(negedge clk);
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    function automatic logic [31:0] token(int alphabet);
        if ($urandom_range(9) == 0)
            return $urandom;
        return $urandom_range(alphabet - 1);
    endfunction

    task automatic run_diff(int na, int nb, int alphabet, int extra);
        int ia, ib;
        ia = 0;
        ib = 0;
        if ($urandom_range(3) != 0)
            send(CMD_CLEAR, $urandom);
        while (ia < na || ib < nb)
        begin
            if (ib >= nb || (ia < na && $urandom_range(1)))
            begin
                send(CMD_APPEND_A, token(alphabet));
                ia++;
            end
            else
            begin
                send(CMD_APPEND_B, token(alphabet));
                ib++;
            end
        end
        if ($urandom_range(9) == 0)
            send(3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST)), $urandom);
        send(CMD_COMPUTE, $urandom);
        repeat (sb.len_a + sb.len_b + extra)
            send(CMD_FETCH, $urandom);
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cycles = 0;
        hold_left = 0;
        src_idle_pct = 9;
        snk_idle_pct = 81;
        cmd.valid = 1'b0;
        cmd.command = CMD_CLEAR;
        cmd.symbol = '0;
        res.ready = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send(CMD_FETCH, '0);
        send(CMD_COMPUTE, '0);
        send(CMD_FETCH, '1);
        send(CMD_APPEND_A, '1);
        send(CMD_APPEND_A, '0);
        send(CMD_APPEND_B, '1);
        send(CMD_SPARE_FIRST, '1);
        send(CMD_SPARE_LAST, '0);
        send(CMD_SPARE_LAST, '1);
        send(CMD_COMPUTE, '0);
        send(CMD_FETCH, '0);
        send(CMD_FETCH, '0);
        send(CMD_FETCH, '0);
        send(CMD_APPEND_B, '0);
        send(CMD_FETCH, '0);
        send(CMD_COMPUTE, '0);
        send(CMD_FETCH, '0);
        send(CMD_FETCH, '0);
        send(CMD_FETCH, '0);
        send(CMD_CLEAR, '0);
        send(CMD_FETCH, '0);

        for (int phase = 0; phase < 3; phase++)
        begin
            src_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 81 : 0;
            snk_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 9 : 0;
            repeat (3)
                run_diff($urandom_range(10), $urandom_range(10),
                         $urandom_range(5, 2), $urandom_range(2));
            if (phase == 2)
            begin
                hold_left = 400;
                run_diff(3, 3, 2, 30);
                drain();
                send(CMD_CLEAR, '0);
                repeat (MAX_LEN + 1)
                    send(CMD_APPEND_A, token(3));
                repeat (4)
                    send(CMD_APPEND_B, token(3));
                send(CMD_COMPUTE, '0);
                repeat (20)
                    send(CMD_FETCH, '0);
                send(CMD_CLEAR, '0);
                run_diff(0, 0, 2, 1);
            end
            drain();
        end

        drain();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
